[hw/rtl/s256mh_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// s256mh_pkg: shared types and constants of the SHA-256 message hash unit
// Holds the block job type passed from the front end to the compression
// engine, the state encodings and the SHA-256 constant tables.
// ----------------------------------------------------------------------------
package s256mh_pkg;

  localparam int unsigned BlkBytes  = 64;
  localparam int unsigned BlkWords  = 16;
  localparam int unsigned NumRounds = 64;
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrW     = $clog2(QDepth);
  localparam int unsigned QCntW     = $clog2(QDepth + 1);

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;
  localparam logic [5:0] LAST_SLOT  = 6'd63;

  // Byte i of a block is element i; byte 0 is the first message byte.
  typedef logic [BlkBytes-1:0][7:0] blk_bytes_t;

  typedef struct packed {
    blk_bytes_t blk;
    logic       last_blk;  // Emit the digest after this block.
  } blk_job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_PAD1,
    F_PAD2
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ROUND,
    B_DONE
  } back_state_e;

  localparam logic [31:0] ROUND_K [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

endpackage
`default_nettype wire

[hw/rtl/s256mh_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// s256mh_in_if: message byte channel
// Carries one optional message byte and the end-of-message mark.
// ----------------------------------------------------------------------------
interface s256mh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, output data_byte, output has_byte, output last,
                  input ready);
  modport sink   (input valid, input data_byte, input has_byte, input last,
                  output ready);
endinterface
`default_nettype wire

[hw/rtl/s256mh_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// s256mh_out_if: digest channel
// Carries the eight 32-bit words of a finished SHA-256 digest.
// ----------------------------------------------------------------------------
interface s256mh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_w0;
  logic [31:0] digest_w1;
  logic [31:0] digest_w2;
  logic [31:0] digest_w3;
  logic [31:0] digest_w4;
  logic [31:0] digest_w5;
  logic [31:0] digest_w6;
  logic [31:0] digest_w7;

  modport source (output valid, output digest_w0, output digest_w1, output digest_w2,
                  output digest_w3, output digest_w4, output digest_w5,
                  output digest_w6, output digest_w7, input ready);
  modport sink   (input valid, input digest_w0, input digest_w1, input digest_w2,
                  input digest_w3, input digest_w4, input digest_w5,
                  input digest_w6, input digest_w7, output ready);
endinterface
`default_nettype wire

[hw/rtl/sha256_message_hash_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_message_hash_unit: streaming SHA-256 hash of a byte stream
// Top level joining the byte front end, the block queue and the engine.
// ----------------------------------------------------------------------------
// The unit hashes a message that arrives one byte per transaction on msg_i
// and returns the standard SHA-256 digest as eight 32-bit words on dig_o,
// word 0 most significant. A transaction with has_byte low carries no byte;
// one with last high ends the message, its own byte (if any) counting first,
// and an end transaction without a byte hashes whatever came before, which
// may be nothing at all. The front end takes one byte per cycle, unless it
// is padding or a full block finds the queue full, into a 64-byte block
// buffer. Each full block goes through a two-entry queue to the compression
// engine, which runs one round per cycle, so a block passes through the
// load, 64 rounds and the chaining add. The engine is therefore what limits
// a long stream, with the queue letting the front end keep taking bytes
// while earlier blocks compress. At the end of a message the front end is
// busy while it pushes one padding block, or two when 56 or more bytes of
// the last block are in use; the digest is registered after the engine has
// compressed the last padding block. The digest sits in an output register,
// so the next message may stream in while it waits to be taken. The message
// length is counted modulo 2^61 bytes, as the standard length field allows.
module sha256_message_hash_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  s256mh_in_if.sink msg_i,
  s256mh_out_if.source dig_o
);
  import s256mh_pkg::*;

  // Front end to queue.
  logic     push_valid;
  logic     push_ready;
  blk_job_t push_job;

  // Queue to engine.
  logic     pop_valid;
  logic     pop_ready;
  blk_job_t pop_job;

  // Gathers bytes, counts the length and builds the padding blocks.
  s256mh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .msg_i        (msg_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  // Decouples byte intake from compression.
  s256mh_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  // Compresses blocks and delivers the digest of each finished message.
  s256mh_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_job_i   (pop_job),
    .dig_o       (dig_o)
  );

endmodule
`default_nettype wire

[hw/rtl/s256mh_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// s256mh_front: byte gathering and padding
// Packs message bytes into a 64-byte block, counts the message length and
// builds the padding blocks at the end of a message.
// ----------------------------------------------------------------------------
module s256mh_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  s256mh_in_if.sink                  msg_i,
  output logic                       push_valid_o,
  input  wire logic                  push_ready_i,
  output s256mh_pkg::blk_job_t       push_job_o
);
  import s256mh_pkg::*;

  front_state_e state_q, state_d;
  logic [5:0]   fill_q, fill_d;
  logic [60:0]  cnt_q, cnt_d;
  blk_bytes_t   blk_buf_q, blk_buf_d;
  logic [63:0]  bit_len;
  blk_bytes_t   pad_blk;
  blk_bytes_t   len_blk;
  logic         accept;
  logic         one_pad_blk;

  assign bit_len     = {cnt_q, 3'b000};
  assign one_pad_blk = (fill_q < LEN_OFFSET);
  assign accept      = msg_i.valid && msg_i.ready;

  // The ready term cannot depend on the payload, so a possible block push
  // is allowed for only when the buffer sits one byte short of full.
  assign msg_i.ready = (state_q == F_IDLE) && (push_ready_i || (fill_q != LAST_SLOT));

  always_comb begin
    pad_blk = '0;
    len_blk = '0;
    for (int i = 0; i < BlkBytes; i++) begin
      if (6'(i) < fill_q) begin
        pad_blk[i] = blk_buf_q[i];
      end else if (6'(i) == fill_q) begin
        pad_blk[i] = PAD_BYTE;
      end
    end
    for (int k = 0; k < 8; k++) begin
      len_blk[BlkBytes-1-k] = bit_len[8*k +: 8];
      if (one_pad_blk) begin
        pad_blk[BlkBytes-1-k] = bit_len[8*k +: 8];
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    cnt_d        = cnt_q;
    blk_buf_d    = blk_buf_q;
    push_valid_o = 1'b0;
    push_job_o   = '{blk: blk_buf_d, last_blk: 1'b0};
    unique case (state_q)
      F_IDLE: begin
        if (accept && msg_i.has_byte) begin
          blk_buf_d[fill_q] = msg_i.data_byte;
          fill_d            = fill_q + 6'd1;
          cnt_d             = cnt_q + 61'd1;
          push_job_o        = '{blk: blk_buf_d, last_blk: 1'b0};
          push_valid_o      = (fill_q == LAST_SLOT);
        end
        if (accept && msg_i.last) begin
          state_d = F_PAD1;
        end
      end
      F_PAD1: begin
        push_valid_o = 1'b1;
        push_job_o   = '{blk: pad_blk, last_blk: one_pad_blk};
        if (push_ready_i) begin
          if (one_pad_blk) begin
            state_d = F_IDLE;
            fill_d  = '0;
            cnt_d   = '0;
          end else begin
            state_d = F_PAD2;
          end
        end
      end
      F_PAD2: begin
        push_valid_o = 1'b1;
        push_job_o   = '{blk: len_blk, last_blk: 1'b1};
        if (push_ready_i) begin
          state_d = F_IDLE;
          fill_d  = '0;
          cnt_d   = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      fill_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_buf_q <= blk_buf_d;
  end

`ifndef SYNTHESIS
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid_o && (state_q == F_IDLE) |-> push_ready_i)
    else $error("front pushed a full block into a full queue");
  a_full_blk_pushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && msg_i.has_byte && (fill_q == LAST_SLOT) |-> push_valid_o)
    else $error("completed block was not handed to the engine");
  a_pad2_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_PAD2) |-> ($past(state_q) == F_PAD1) || ($past(state_q) == F_PAD2))
    else $error("length block without a preceding padding block");
`endif

endmodule
`default_nettype wire

[hw/rtl/s256mh_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// s256mh_queue: block job queue
// Two-entry queue of block jobs between the front end and the engine.
// ----------------------------------------------------------------------------
module s256mh_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_valid_i,
  output logic                       push_ready_o,
  input  s256mh_pkg::blk_job_t       push_job_i,
  output logic                       pop_valid_o,
  input  wire logic                  pop_ready_i,
  output s256mh_pkg::blk_job_t       pop_job_o
);
  import s256mh_pkg::*;

  blk_job_t         jobs_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != QCntW'(QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_job_o    = jobs_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      jobs_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/s256mh_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// s256mh_engine: SHA-256 compression engine
// Runs one compression round per cycle on queued blocks, keeps the chaining
// value and registers the digest for the output channel.
// ----------------------------------------------------------------------------
module s256mh_engine (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  pop_valid_i,
  output logic                       pop_ready_o,
  input  s256mh_pkg::blk_job_t       pop_job_i,
  s256mh_out_if.source               dig_o
);
  import s256mh_pkg::*;

  function automatic logic [31:0] rotr(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  back_state_e state_q, state_d;
  logic [5:0]  rnd_q, rnd_d;
  logic        job_last_q, job_last_d;
  logic [31:0] chain_q [8];
  logic [31:0] chain_d [8];
  logic [31:0] v_q [8];
  logic [31:0] v_d [8];
  logic [31:0] w_q [BlkWords];
  logic [31:0] w_d [BlkWords];
  logic [31:0] dig_q [8];
  logic [31:0] dig_d [8];
  logic        out_valid_q, out_valid_d;
  logic [31:0] sum [8];
  logic [31:0] big_s0, big_s1, ch, maj, t1, t2, sm_s0, sm_s1;

  always_comb begin
    big_s1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    ch     = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1     = v_q[7] + big_s1 + ch + ROUND_K[rnd_q] + w_q[0];
    big_s0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    maj    = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2     = big_s0 + maj;
    sm_s0  = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    sm_s1  = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    for (int i = 0; i < 8; i++) begin
      sum[i] = chain_q[i] + v_q[i];
    end
  end

  assign pop_ready_o = (state_q == B_IDLE);

  always_comb begin
    state_d     = state_q;
    rnd_d       = rnd_q;
    job_last_d  = job_last_q;
    chain_d     = chain_q;
    v_d         = v_q;
    w_d         = w_q;
    dig_d       = dig_q;
    out_valid_d = out_valid_q && !dig_o.ready;
    unique case (state_q)
      B_IDLE: begin
        if (pop_valid_i) begin
          for (int j = 0; j < BlkWords; j++) begin
            w_d[j] = {pop_job_i.blk[4*j], pop_job_i.blk[4*j+1],
                      pop_job_i.blk[4*j+2], pop_job_i.blk[4*j+3]};
          end
          v_d        = chain_q;
          rnd_d      = '0;
          job_last_d = pop_job_i.last_blk;
          state_d    = B_ROUND;
        end
      end
      B_ROUND: begin
        v_d[7] = v_q[6];
        v_d[6] = v_q[5];
        v_d[5] = v_q[4];
        v_d[4] = v_q[3] + t1;
        v_d[3] = v_q[2];
        v_d[2] = v_q[1];
        v_d[1] = v_q[0];
        v_d[0] = t1 + t2;
        for (int j = 0; j < BlkWords - 1; j++) begin
          w_d[j] = w_q[j+1];
        end
        w_d[BlkWords-1] = sm_s1 + w_q[9] + sm_s0 + w_q[0];
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'(NumRounds - 1)) begin
          state_d = B_DONE;
        end
      end
      B_DONE: begin
        if (!job_last_q) begin
          chain_d = sum;
          state_d = B_IDLE;
        end else if (!out_valid_q || dig_o.ready) begin
          // Final block of a message: publish the digest and restart the chain.
          dig_d       = sum;
          out_valid_d = 1'b1;
          chain_d     = INIT_H;
          state_d     = B_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      rnd_q       <= '0;
      job_last_q  <= 1'b0;
      chain_q     <= INIT_H;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      job_last_q  <= job_last_d;
      chain_q     <= chain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    w_q   <= w_d;
    dig_q <= dig_d;
  end

  assign dig_o.valid     = out_valid_q;
  assign dig_o.digest_w0 = dig_q[0];
  assign dig_o.digest_w1 = dig_q[1];
  assign dig_o.digest_w2 = dig_q[2];
  assign dig_o.digest_w3 = dig_q[3];
  assign dig_o.digest_w4 = dig_q[4];
  assign dig_o.digest_w5 = dig_q[5];
  assign dig_o.digest_w6 = dig_q[6];
  assign dig_o.digest_w7 = dig_q[7];

`ifndef SYNTHESIS
  a_rnd_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DONE) |-> (rnd_q == 6'd0) &&
      (($past(state_q) == B_ROUND) || ($past(state_q) == B_DONE)))
    else $error("engine finished a block without all rounds");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !dig_o.ready |=> out_valid_q && $stable(dig_q[0]))
    else $error("pending digest lost or changed");
  a_chain_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (chain_q[0] == INIT_H[0]) && (chain_q[7] == INIT_H[7]))
    else $error("chaining value not restarted after a digest");
`endif

endmodule
`default_nettype wire
